[hw/rtl/d2q9_pkg.sv]
`timescale 1ns / 1ps
// Package: types, constants and saturating Q4.28 helpers for the D2Q9 collision block.
package d2q9_pkg;

  localparam int DW        = 32;
  localparam int FRAC      = 28;
  localparam int NDIR      = 9;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 2 * DW + 1 - FRAC;

  localparam int SUM_STEPS = 4;
  localparam int DIV_STEPS = DW - 1;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int LANE_LAT  = 14;
  localparam int PIPE_LAT  = 1 + SUM_STEPS + DIV_LAT + 1 + LANE_LAT + 1;

  typedef logic signed [DW-1:0]  sval_t;
  typedef logic [2*DW-1:0]       prod_t;
  typedef logic [NDIR-1:0][DW-1:0] popv_t;

  typedef struct packed {
    logic  neg;
    prod_t mag;
  } mprod_t;

  typedef struct packed {
    popv_t f;
    sval_t rho;
    logic  bad;
  } carry_t;

  typedef struct packed {
    sval_t pop_rest;
    sval_t pop_east;
    sval_t pop_north;
    sval_t pop_west;
    sval_t pop_south;
    sval_t pop_northeast;
    sval_t pop_northwest;
    sval_t pop_southwest;
    sval_t pop_southeast;
  } in_word_t;

  typedef struct packed {
    sval_t post_rest;
    sval_t post_east;
    sval_t post_north;
    sval_t post_west;
    sval_t post_south;
    sval_t post_northeast;
    sval_t post_northwest;
    sval_t post_southwest;
    sval_t post_southeast;
    logic  bad_density;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OMEGA   = 2'd0,
    REG_SHIFT_X = 2'd1,
    REG_SHIFT_Y = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] OMEGA_RST   = 30'd28726111;
  localparam logic [CFG_W-1:0] SHIFT_X_RST = 30'd2508;
  localparam logic [CFG_W-1:0] SHIFT_Y_RST = 30'd0;

  localparam sval_t SMAX  = {1'b0, {(DW-1){1'b1}}};
  localparam sval_t SMIN  = {1'b1, {(DW-1){1'b0}}};
  localparam sval_t ONE_Q = sval_t'(1 << FRAC);
  localparam sval_t C3    = sval_t'(3 * (1 << FRAC));
  localparam sval_t C45   = sval_t'(9 * (1 << (FRAC - 1)));
  localparam sval_t C15   = sval_t'(3 * (1 << (FRAC - 1)));

  localparam int    DIR_CX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int    DIR_CY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam sval_t DIR_W  [NDIR] = '{119304647, 29826162, 29826162, 29826162,
                                      29826162, 7456540, 7456540, 7456540, 7456540};

  // Saturating add chains, two operations per stage; the first term is loaded at input.
  localparam int RHO_SEL [8] = '{1, 2, 3, 4, 5, 6, 7, 8};
  localparam int MX_SEL  [8] = '{5, 8, 3, 6, 7, 0, 0, 0};
  localparam int MX_SUB  [8] = '{0, 0, 1, 1, 1, 0, 0, 0};
  localparam int MY_SEL  [8] = '{5, 6, 4, 7, 8, 0, 0, 0};
  localparam int MY_SUB  [8] = '{0, 0, 1, 1, 1, 0, 0, 0};
  localparam int M_OPS       = 5;

  function automatic sval_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    sval_t r;
    if (mag > {{(MAG_W-DW){1'b0}}, SMAX}) r = neg ? SMIN : SMAX;
    else if (neg) r = -sval_t'(mag[DW-1:0]);
    else r = sval_t'(mag[DW-1:0]);
    return r;
  endfunction

  function automatic sval_t sadd(input sval_t a, input sval_t b);
    logic [DW:0] s;
    sval_t r;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) r = s[DW] ? SMIN : SMAX;
    else r = sval_t'(s[DW-1:0]);
    return r;
  endfunction

  function automatic sval_t sneg(input sval_t a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  function automatic sval_t ssub(input sval_t a, input sval_t b);
    return sadd(a, sneg(b));
  endfunction

  function automatic logic [DW-1:0] mag_of(input sval_t a);
    logic [DW-1:0] x;
    x = a;
    return a[DW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic sval_t acc_op(input sval_t acc, input sval_t val,
                                   input logic en, input logic sub);
    sval_t r;
    if (!en) r = acc;
    else if (sub) r = ssub(acc, val);
    else r = sadd(acc, val);
    return r;
  endfunction

  // Product magnitude and sign; rounding happens one register later.
  function automatic mprod_t qmul_m(input sval_t a, input sval_t b);
    mprod_t m;
    m.neg = a[DW-1] ^ b[DW-1];
    m.mag = prod_t'(mag_of(a)) * prod_t'(mag_of(b));
    return m;
  endfunction

  function automatic sval_t qmul_r(input mprod_t m);
    logic [2*DW:0] r;
    r = {1'b0, m.mag} + ((2*DW+1)'(1) << (FRAC - 1));
    return sat_mag(m.neg, r[2*DW:FRAC]);
  endfunction

  function automatic sval_t shift_ext(input logic [CFG_W-1:0] x);
    return sval_t'({{(DW-CFG_W){x[CFG_W-1]}}, x});
  endfunction

endpackage

[hw/rtl/d2q9_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: saturated (num << FRAC) / den, one quotient bit per stage.
module d2q9_div import d2q9_pkg::*; (
  input  logic  clk,
  input  sval_t num,
  input  sval_t den,
  output sval_t quo
);

  localparam int PRE = DW - 1 - FRAC;
  localparam int DW1 = DW - 1;

  logic [DW1-1:0] rem [DIV_STEPS+1];
  logic [DW1-1:0] qb  [DIV_STEPS+1];
  logic [DW1-1:0] dd  [DIV_STEPS+1];
  logic [PRE-1:0] nb  [DIV_STEPS+1];
  logic           sg  [DIV_STEPS+1];
  logic           ov  [DIV_STEPS+1];
  logic [DW-1:0]  n_mag;

  assign n_mag = mag_of(num);

  // Quotient of 2^(DW-1) or more saturates; otherwise the top bits are known zero.
  always_ff @(posedge clk) begin
    rem[0] <= DW1'(n_mag >> PRE);
    qb[0]  <= '0;
    dd[0]  <= den[DW1-1:0];
    nb[0]  <= n_mag[PRE-1:0];
    sg[0]  <= num[DW-1];
    ov[0]  <= (DW1+PRE)'(n_mag) >= {den[DW1-1:0], {PRE{1'b0}}};
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic         b;
    logic [DW1:0] t;
    logic [DW1:0] diff;
    logic         ge;

    if (k <= PRE) begin : g_nb
      assign b = nb[k-1][PRE-k];
    end else begin : g_zero
      assign b = 1'b0;
    end

    always_comb begin
      t    = {rem[k-1], b};
      diff = t - {1'b0, dd[k-1]};
      ge   = t >= {1'b0, dd[k-1]};
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[DW1-1:0] : t[DW1-1:0];
      qb[k]  <= {qb[k-1][DW1-2:0], ge};
      dd[k]  <= dd[k-1];
      nb[k]  <= nb[k-1];
      sg[k]  <= sg[k-1];
      ov[k]  <= ov[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ov[DIV_STEPS]) quo <= sg[DIV_STEPS] ? SMIN : SMAX;
    else if (sg[DIV_STEPS]) quo <= -sval_t'({1'b0, qb[DIV_STEPS]});
    else quo <= sval_t'({1'b0, qb[DIV_STEPS]});
  end

endmodule

[hw/rtl/d2q9_lane.sv]
`timescale 1ns / 1ps
// One direction lane: equilibrium for its velocity vector and BGK relaxation.
module d2q9_lane import d2q9_pkg::*; #(
  parameter int DIR = 0
) (
  input  logic             clk,
  input  sval_t            u,
  input  sval_t            v,
  input  sval_t            sq15,
  input  sval_t            rho,
  input  sval_t            f,
  input  logic [CFG_W-1:0] omega,
  output sval_t            post,
  output sval_t            f_pass
);

  localparam int    CX  = DIR_CX[DIR];
  localparam int    CY  = DIR_CY[DIR];
  localparam sval_t WGT = DIR_W[DIR];

  sval_t  cu_next, cu;
  mprod_t m3, mcc, m45, mw, mf, mo;
  sval_t  p3, pcc, term1_a, term1_b, p45, term3, tw, feq, dlt, relax;
  sval_t  f_d   [LANE_LAT];
  sval_t  rho_d [8];

  always_comb begin
    cu_next = '0;
    if (CX > 0) cu_next = sadd(cu_next, u);
    if (CX < 0) cu_next = ssub(cu_next, u);
    if (CY > 0) cu_next = sadd(cu_next, v);
    if (CY < 0) cu_next = ssub(cu_next, v);
  end

  always_ff @(posedge clk) begin
    cu      <= cu_next;
    m3      <= qmul_m(cu, C3);
    mcc     <= qmul_m(cu, cu);
    p3      <= qmul_r(m3);
    pcc     <= qmul_r(mcc);
    term1_a <= sadd(ONE_Q, p3);
    m45     <= qmul_m(pcc, C45);
    term1_b <= term1_a;
    p45     <= qmul_r(m45);
    term3   <= ssub(sadd(term1_b, p45), sq15);
    mw      <= qmul_m(term3, WGT);
    tw      <= qmul_r(mw);
    mf      <= qmul_m(rho_d[7], tw);
    feq     <= qmul_r(mf);
    dlt     <= ssub(f_d[9], feq);
    mo      <= qmul_m(sval_t'({{(DW-CFG_W){1'b0}}, omega}), dlt);
    relax   <= qmul_r(mo);
    post    <= ssub(f_d[12], relax);
  end

  always_ff @(posedge clk) begin
    f_d[0]   <= f;
    rho_d[0] <= rho;
    for (int i = 1; i < LANE_LAT; i++) f_d[i] <= f_d[i-1];
    for (int i = 1; i < 8; i++) rho_d[i] <= rho_d[i-1];
  end

  assign f_pass = f_d[LANE_LAT-1];

endmodule

[hw/rtl/d2q9_bgk_collision_force_shift_top.sv]
`timescale 1ns / 1ps
// Top level: D2Q9 BGK collision with force-shifted equilibrium velocity, one cell per cycle outside reset.
//
// Usage:
//   Input channel: drive din with the nine populations of a cell and raise start;
//   the word is taken at every rising edge where start is high and busy is low.
//   busy is high only while rst is high, so a word can enter every cycle.
//   Output channel: done pulses for one cycle with the relaxed cell on dout.
//   The receiver has no way to hold results off; capture dout when done is high.
//   From accept to done a word passes the input register, four stages of
//   saturating sums, a 33-stage bit-per-stage divider for each velocity
//   component, a velocity register, 14 stages of the nine parallel
//   direction lanes, and the merge/output register.
//   Throughput is one cell per cycle outside reset.
//   Configuration: write cfg_data to register cfg_index when cfg_we is high
//   (0 relaxation rate, 1 x shift, 2 y shift; index 3 is ignored). Write only
//   while no cell is in flight.
//   Reset (synchronous, rst high) drops every cell in flight and loads the
//   register defaults.
//   A cell with non-positive density leaves with its input populations and
//   bad_density set.
module d2q9_bgk_collision_force_shift_top import d2q9_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             din,
  output logic                 done,
  output out_word_t            dout,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]    omega, shift_x, shift_y;
  logic [PIPE_LAT-1:0] vld;
  logic                accept;

  sval_t  sf   [SUM_STEPS+1][NDIR];
  sval_t  srho [SUM_STEPS+1];
  sval_t  smx  [SUM_STEPS+1];
  sval_t  smy  [SUM_STEPS+1];
  carry_t carry_in;
  carry_t dly  [DIV_LAT];
  carry_t p1;
  sval_t  qx, qy, u, v, uu, vv, sq, sq15;
  mprod_t muu, mvv, msq;
  sval_t  lane_post [NDIR];
  sval_t  lane_f    [NDIR];
  sval_t  res       [NDIR];
  logic [LANE_LAT-1:0] bad_d;

  // Hold off input only during reset.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      omega   <= OMEGA_RST;
      shift_x <= SHIFT_X_RST;
      shift_y <= SHIFT_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OMEGA:   omega   <= cfg_data;
        REG_SHIFT_X: shift_x <= cfg_data;
        REG_SHIFT_Y: shift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the valid marks alongside the data; payload registers run freely.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  // Capture the word and seed each sum chain with its first term.
  always_ff @(posedge clk) begin
    sf[0][0] <= din.pop_rest;
    sf[0][1] <= din.pop_east;
    sf[0][2] <= din.pop_north;
    sf[0][3] <= din.pop_west;
    sf[0][4] <= din.pop_south;
    sf[0][5] <= din.pop_northeast;
    sf[0][6] <= din.pop_northwest;
    sf[0][7] <= din.pop_southwest;
    sf[0][8] <= din.pop_southeast;
    srho[0]  <= din.pop_rest;
    smx[0]   <= din.pop_east;
    smy[0]   <= din.pop_north;
  end

  // Density and momentum: saturate after every add, in model order, two ops per stage.
  for (genvar k = 1; k <= SUM_STEPS; k++) begin : g_sum
    localparam int J0 = 2 * k - 2;
    localparam int J1 = 2 * k - 1;
    always_ff @(posedge clk) begin
      sf[k]   <= sf[k-1];
      srho[k] <= acc_op(acc_op(srho[k-1], sf[k-1][RHO_SEL[J0]], 1'b1, 1'b0),
                        sf[k-1][RHO_SEL[J1]], 1'b1, 1'b0);
      smx[k]  <= acc_op(acc_op(smx[k-1], sf[k-1][MX_SEL[J0]], J0 < M_OPS, MX_SUB[J0] != 0),
                        sf[k-1][MX_SEL[J1]], J1 < M_OPS, MX_SUB[J1] != 0);
      smy[k]  <= acc_op(acc_op(smy[k-1], sf[k-1][MY_SEL[J0]], J0 < M_OPS, MY_SUB[J0] != 0),
                        sf[k-1][MY_SEL[J1]], J1 < M_OPS, MY_SUB[J1] != 0);
    end
  end

  always_comb begin
    for (int i = 0; i < NDIR; i++) carry_in.f[i] = sf[SUM_STEPS][i];
    carry_in.rho = srho[SUM_STEPS];
    carry_in.bad = srho[SUM_STEPS] <= 0;
  end

  // Velocity components: momentum over density.
  d2q9_div u_div_x (.clk(clk), .num(smx[SUM_STEPS]), .den(srho[SUM_STEPS]), .quo(qx));
  d2q9_div u_div_y (.clk(clk), .num(smy[SUM_STEPS]), .den(srho[SUM_STEPS]), .quo(qy));

  // Carry populations, density and flag past the dividers.
  always_ff @(posedge clk) begin
    dly[0] <= carry_in;
    for (int i = 1; i < DIV_LAT; i++) dly[i] <= dly[i-1];
  end

  // Add the force shift, then build 1.5 |u|^2 while the lanes start on c.u.
  always_ff @(posedge clk) begin
    u    <= sadd(qx, shift_ext(shift_x));
    v    <= sadd(qy, shift_ext(shift_y));
    p1   <= dly[DIV_LAT-1];
    muu  <= qmul_m(u, u);
    mvv  <= qmul_m(v, v);
    uu   <= qmul_r(muu);
    vv   <= qmul_r(mvv);
    sq   <= sadd(uu, vv);
    msq  <= qmul_m(sq, C15);
    sq15 <= qmul_r(msq);
  end

  for (genvar i = 0; i < NDIR; i++) begin : g_lane
    d2q9_lane #(.DIR(i)) u_lane (
      .clk   (clk),
      .u     (u),
      .v     (v),
      .sq15  (sq15),
      .rho   (p1.rho),
      .f     (sval_t'(p1.f[i])),
      .omega (omega),
      .post  (lane_post[i]),
      .f_pass(lane_f[i])
    );
  end

  always_ff @(posedge clk) begin
    bad_d <= {bad_d[LANE_LAT-2:0], p1.bad};
  end

  // Merge: a cell with non-positive density passes its inputs through.
  always_comb begin
    for (int i = 0; i < NDIR; i++) res[i] = bad_d[LANE_LAT-1] ? lane_f[i] : lane_post[i];
  end

  always_ff @(posedge clk) begin
    dout.post_rest      <= res[0];
    dout.post_east      <= res[1];
    dout.post_north     <= res[2];
    dout.post_west      <= res[3];
    dout.post_south     <= res[4];
    dout.post_northeast <= res[5];
    dout.post_northwest <= res[6];
    dout.post_southwest <= res[7];
    dout.post_southeast <= res[8];
    dout.bad_density    <= bad_d[LANE_LAT-1];
  end

  assign done = vld[PIPE_LAT-1];

endmodule

[hw/rtl/d2q9_checker.sv]
`timescale 1ns / 1ps
// Port checker for the D2Q9 collision top level, with its bind.
module d2q9_checker import d2q9_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input in_word_t  din,
  input out_word_t dout
);

  a_done_from_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without an accepted input word");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

  a_bad_rest: assert property (@(posedge clk) disable iff (rst)
    done && dout.bad_density |-> dout.post_rest == $past(din.pop_rest, PIPE_LAT))
    else $error("bad density word did not pass rest population");

  a_bad_southeast: assert property (@(posedge clk) disable iff (rst)
    done && dout.bad_density |-> dout.post_southeast == $past(din.pop_southeast, PIPE_LAT))
    else $error("bad density word did not pass southeast population");

endmodule

bind d2q9_bgk_collision_force_shift_top d2q9_checker u_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .din  (din),
  .dout (dout)
);
